// ===== rtl/chth_pkg.sv =====
package chth_pkg;

   // table geometry
   localparam int BUCKETS = 1021;
   localparam int NODES   = 4096;

   // field widths
   localparam int KEY_W  = 63;
   localparam int CNT_W  = 32;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int NODE_W = $clog2(NODES);

   // bucket residue unit: key bits consumed per cycle
   localparam int DIG_W     = 8;
   localparam int DIG_N     = (KEY_W + DIG_W - 1) / DIG_W;
   localparam int SH_W      = DIG_N * DIG_W;
   localparam int DIG_CNT_W = (DIG_N > 1) ? $clog2(DIG_N) : 1;

   // operation codes
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

endpackage

// ===== rtl/chained_hash_counter_table_top.sv =====
// channel   | ports                                   | dir | beat taken when
// request   | start, busy, req_func/key/delta         | in  | start && !busy at clock edge
// response  | rsp_valid, rsp_count/found/full_res     | out | every cycle rsp_valid is high
//
// after reset the bucket heads are swept to empty, one per cycle, with busy high
// an item first has its bucket residue formed (8 key bits per cycle), then one head read
// and one node memory read per chain node visited; both memory reads are registered
// one item is in flight at a time; busy drops the cycle its response shows
// the receiver cannot stall: a response is valid for exactly one cycle
module chained_hash_counter_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [chth_pkg::KEY_W-1:0]          req_key,
   input  logic signed [chth_pkg::CNT_W-1:0]   req_delta,
   output logic                                rsp_valid,
   output logic signed [chth_pkg::CNT_W-1:0]   rsp_count,
   output logic                                rsp_found,
   output logic                                rsp_full_res
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_HASH  = 6'b000100,
      ST_HEAD  = 6'b001000,
      ST_CHK   = 6'b010000,
      ST_WALK  = 6'b100000
   } state_type;

   typedef struct packed {
      logic [chth_pkg::NODE_W-1:0] link;
      logic [chth_pkg::KEY_W-1:0]  key;
      logic [chth_pkg::CNT_W-1:0]  count;
   } node_type;

   // memories
   logic [chth_pkg::NODE_W-1:0] head_mem [chth_pkg::BUCKETS];
   node_type                    node_mem [chth_pkg::NODES];

   // registers
   state_type                    state_ff, state_in;
   logic                         func_ff;
   logic [chth_pkg::KEY_W-1:0]   key_ff;
   logic [chth_pkg::CNT_W-1:0]   delta_ff;
   logic [chth_pkg::BKT_W-1:0]   bucket_ff;
   logic [chth_pkg::NODE_W-1:0]  ptr_ff, ptr_in;
   logic [chth_pkg::NODE_W-1:0]  used_ff;
   logic [chth_pkg::BKT_W-1:0]   clr_ff;
   logic [chth_pkg::NODE_W-1:0]  head_rd_ff;
   node_type                     node_rd_ff;
   logic                         rsp_valid_ff;
   logic [chth_pkg::CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic                         rsp_full_ff, rsp_full_in;

   // memory ports
   logic                         head_we, head_re;
   logic [chth_pkg::BKT_W-1:0]   head_wa;
   logic [chth_pkg::NODE_W-1:0]  head_wd;
   logic                         node_we, node_re;
   logic [chth_pkg::NODE_W-1:0]  node_wa, node_ra;
   node_type                     node_wd;

   // walk decisions
   logic                         accept;
   logic                         key_hit, hit, miss, finish, room;
   logic [chth_pkg::NODE_W-1:0]  fresh;
   logic [chth_pkg::CNT_W-1:0]   sum;
   logic                         mod_done;
   logic [chth_pkg::BKT_W-1:0]   mod_res;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   chth_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .go      (accept),
      .key_in  (req_key),
      .done    (mod_done),
      .residue (mod_res)
   );

   assign key_hit = (node_rd_ff.key == key_ff);
   assign hit     = (state_ff == ST_WALK) && key_hit;
   assign miss    = ((state_ff == ST_CHK) && (head_rd_ff == '0))
                 || ((state_ff == ST_WALK) && !key_hit && (node_rd_ff.link == '0));
   assign finish  = hit || miss;
   assign room    = (used_ff < chth_pkg::NODE_W'(chth_pkg::NODES - 1));
   assign fresh   = used_ff + chth_pkg::NODE_W'(1);
   assign sum     = node_rd_ff.count + delta_ff;

   // sequencing and memory control
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      head_we      = 1'b0;
      head_wa      = bucket_ff;
      head_wd      = fresh;
      head_re      = 1'b0;
      node_we      = 1'b0;
      node_wa      = ptr_ff;
      node_wd      = node_rd_ff;
      node_re      = 1'b0;
      node_ra      = node_rd_ff.link;
      rsp_count_in = '0;
      rsp_found_in = 1'b0;
      rsp_full_in  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = '0;
            if (clr_ff == chth_pkg::BKT_W'(chth_pkg::BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            head_re  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (head_rd_ff != '0) begin
               node_re  = 1'b1;
               node_ra  = head_rd_ff;
               ptr_in   = head_rd_ff;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!finish) begin
               node_re = 1'b1;
               node_ra = node_rd_ff.link;
               ptr_in  = node_rd_ff.link;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // end of walk: on an add, update the table if room allows, and form the response
      if (finish) begin
         state_in = ST_IDLE;
         if (hit) begin
            rsp_found_in = 1'b1;
            if (func_ff == chth_pkg::FUNC_ADD) begin
               node_we       = 1'b1;
               node_wa       = ptr_ff;
               node_wd       = node_rd_ff;
               node_wd.count = sum;
               rsp_count_in  = sum;
            end else begin
               rsp_count_in  = node_rd_ff.count;
            end
         end else if (func_ff == chth_pkg::FUNC_ADD) begin
            if (room) begin
               // new node goes in front of the chain
               node_we       = 1'b1;
               node_wa       = fresh;
               node_wd.link  = head_rd_ff;
               node_wd.key   = key_ff;
               node_wd.count = delta_ff;
               head_we       = 1'b1;
               head_wa       = bucket_ff;
               head_wd       = fresh;
               rsp_count_in  = delta_ff;
            end else begin
               rsp_full_in   = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + chth_pkg::BKT_W'(1);
         end
         if (finish && !hit && (func_ff == chth_pkg::FUNC_ADD) && room) begin
            used_ff <= fresh;
         end
      end
   end

   // item and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         delta_ff <= req_delta;
      end
      if ((state_ff == ST_HASH) && mod_done) begin
         bucket_ff <= mod_res;
      end
      ptr_ff <= ptr_in;
      if (finish) begin
         rsp_count_ff <= rsp_count_in;
         rsp_found_ff <= rsp_found_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   // bucket head memory; items run one at a time, so writes land before the next read
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[bucket_ff];
      end
   end

   // node memory: link, key and count in one word
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      if (node_re) begin
         node_rd_ff <= node_mem[node_ra];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_full_res = rsp_full_ff;

   // a response closes a walk that was running
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("response without an item in flight");

   // a refused add reports nothing else
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> !rsp_found && (rsp_count == '0))
      else $error("pool full response carries data");

   // node pool never passes its last node
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= chth_pkg::NODE_W'(chth_pkg::NODES - 1))
      else $error("node pool overrun");

   // a new node is only taken by an add of an absent key
   a_pool_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |-> rsp_valid && !rsp_found && !rsp_full_res
         && (used_ff == $past(used_ff) + chth_pkg::NODE_W'(1)))
      else $error("node pool moved without an insert");

endmodule

// ===== rtl/chth_mod_unit.sv =====
// key modulo bucket count, one digit of the key per cycle
module chth_mod_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [chth_pkg::KEY_W-1:0]       key_in,
   output logic                             done,
   output logic [chth_pkg::BKT_W-1:0]       residue
);

   logic                               run_ff;
   logic                               done_ff;
   logic [chth_pkg::DIG_CNT_W-1:0]     cnt_ff;
   logic [chth_pkg::SH_W-1:0]          sh_ff;
   logic [chth_pkg::BKT_W-1:0]         res_ff;
   logic [chth_pkg::BKT_W-1:0]         res_in;
   logic                               last;

   // shift one digit into the remainder, bit by bit with compare and subtract
   function automatic logic [chth_pkg::BKT_W-1:0] fold(
      input logic [chth_pkg::BKT_W-1:0] r,
      input logic [chth_pkg::DIG_W-1:0] d
   );
      logic [chth_pkg::BKT_W:0]   t;
      logic [chth_pkg::BKT_W-1:0] acc;
      acc = r;
      for (int i = chth_pkg::DIG_W - 1; i >= 0; i--) begin
         t = {acc, d[i]};
         if (t >= (chth_pkg::BKT_W + 1)'(chth_pkg::BUCKETS)) begin
            t = t - (chth_pkg::BKT_W + 1)'(chth_pkg::BUCKETS);
         end
         acc = t[chth_pkg::BKT_W-1:0];
      end
      return acc;
   endfunction

   assign res_in = fold(res_ff, sh_ff[chth_pkg::SH_W-1 -: chth_pkg::DIG_W]);
   assign last   = (cnt_ff == chth_pkg::DIG_CNT_W'(chth_pkg::DIG_N - 1));

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && last;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + chth_pkg::DIG_CNT_W'(1);
            if (last) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // datapath, most significant digit first
   always_ff @(posedge clock) begin
      if (go) begin
         sh_ff  <= chth_pkg::SH_W'(key_in);
         res_ff <= '0;
      end else if (run_ff) begin
         sh_ff  <= sh_ff << chth_pkg::DIG_W;
         res_ff <= res_in;
      end
   end

   assign done    = done_ff;
   assign residue = res_ff;

   // residue stays below the bucket count
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (residue < chth_pkg::BKT_W'(chth_pkg::BUCKETS)))
      else $error("bucket residue out of range");

   // done follows the last digit step
   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(run_ff))
      else $error("residue done without a running division");

   // one done per run
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("residue done held for two cycles");

endmodule

// ===== bench/tb_chained_hash_counter_table_top.sv =====
`timescale 1ns / 100ps

module tb_chained_hash_counter_table_top;

   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int RANDOM_PER_PHASE = 360;
   localparam int MAX_REPORTS      = 50;

   localparam logic signed [chth_pkg::CNT_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [chth_pkg::CNT_W-1:0] CNT_MIN = 32'sh8000_0000;
   localparam logic [chth_pkg::KEY_W-1:0]        KEY_MAX = {chth_pkg::KEY_W{1'b1}};

   // one response beat as the table should give it
   typedef struct {
      logic signed [chth_pkg::CNT_W-1:0] count;
      logic                              found;
      logic                              full_res;
   } count_beat_type;

   // mirror of the chained table plus the responses still owed
   class count_table_tracker;
      logic [chth_pkg::NODE_W-1:0]       chain_head [chth_pkg::BUCKETS];
      logic [chth_pkg::NODE_W-1:0]       next_node  [chth_pkg::NODES];
      logic [chth_pkg::KEY_W-1:0]        slot_key   [chth_pkg::NODES];
      logic signed [chth_pkg::CNT_W-1:0] slot_count [chth_pkg::NODES];
      int                                nodes_taken;
      int                                errors;
      count_beat_type                    expected_counts [$];

      function new();
         foreach (chain_head[i]) chain_head[i] = '0;
         foreach (next_node[i]) begin
            next_node[i]  = '0;
            slot_key[i]   = '0;
            slot_count[i] = '0;
         end
         nodes_taken = 0;
         errors      = 0;
      endfunction

      // walk the key's chain and apply the operation to the mirror
      function void note_request(logic func, logic [chth_pkg::KEY_W-1:0] key,
                                 logic signed [chth_pkg::CNT_W-1:0] delta);
         int                          bucket;
         int                          steps;
         logic [chth_pkg::NODE_W-1:0] walk;
         logic [chth_pkg::NODE_W-1:0] hit;
         logic [chth_pkg::NODE_W-1:0] fresh;
         count_beat_type              want;
         bucket = int'(64'(key) % 64'(chth_pkg::BUCKETS));
         walk   = chain_head[bucket];
         hit    = '0;
         steps  = 0;
         while (walk != '0 && hit == '0 && steps < chth_pkg::NODES) begin
            if (slot_key[walk] == key) hit = walk;
            else walk = next_node[walk];
            steps++;
         end
         want.count    = '0;
         want.found    = (hit != '0);
         want.full_res = 1'b0;
         if (func == chth_pkg::FUNC_LOOKUP) begin
            if (hit != '0) want.count = slot_count[hit];
         end else if (hit != '0) begin
            slot_count[hit] = slot_count[hit] + delta;
            want.count      = slot_count[hit];
         end else if (nodes_taken + 1 < chth_pkg::NODES) begin
            // new key goes to the next free node, linked at the chain head
            fresh              = chth_pkg::NODE_W'(nodes_taken + 1);
            nodes_taken        = nodes_taken + 1;
            slot_key[fresh]    = key;
            slot_count[fresh]  = delta;
            next_node[fresh]   = chain_head[bucket];
            chain_head[bucket] = fresh;
            want.count         = delta;
         end else begin
            want.full_res = 1'b1;
         end
         expected_counts.push_back(want);
      endfunction

      function void flag(string field, logic signed [63:0] want, logic signed [63:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
      endfunction

      // compare one response beat with the oldest owed one
      function void check_response(logic signed [chth_pkg::CNT_W-1:0] count, logic found,
                                   logic full_res);
         count_beat_type want;
         if (expected_counts.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: expected none actual count %0d",
                     $time, count);
            return;
         end
         want = expected_counts.pop_front();
         if (count !== want.count) flag("count", want.count, count);
         if (found !== want.found) flag("found", want.found, found);
         if (full_res !== want.full_res) flag("full_res", want.full_res, full_res);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_func;
   logic [chth_pkg::KEY_W-1:0]        req_key;
   logic signed [chth_pkg::CNT_W-1:0] req_delta;
   logic                              rsp_valid;
   logic signed [chth_pkg::CNT_W-1:0] rsp_count;
   logic                              rsp_found;
   logic                              rsp_full_res;

   count_table_tracker                tracker;
   logic [chth_pkg::KEY_W-1:0]        known_keys [$];
   int                                stall_cycles = 0;
   int                                idle_pct [3] = '{0, 86, 37};

   chained_hash_counter_table_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_key      (req_key),
      .req_delta    (req_delta),
      .rsp_valid    (rsp_valid),
      .rsp_count    (rsp_count),
      .rsp_found    (rsp_found),
      .rsp_full_res (rsp_full_res)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sample both channels at the rising edge; response first, it belongs to the older item
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1) tracker.check_response(rsp_count, rsp_found, rsp_full_res);
         if (start === 1'b1 && busy === 1'b0) tracker.note_request(req_func, req_key, req_delta);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_chained_hash_counter_table_top: FAIL");
         $finish;
      end
   end

   // drive one request beat from a falling edge and hold it until taken
   task automatic send_item(input logic func, input logic [chth_pkg::KEY_W-1:0] key,
                            input logic signed [chth_pkg::CNT_W-1:0] delta);
      start     = 1'b1;
      req_func  = func;
      req_key   = key;
      req_delta = delta;
      if (func == chth_pkg::FUNC_ADD) known_keys.push_back(key);
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // sender gap of random length, fields carry noise meanwhile
   task automatic hold_off(input int pct);
      while ($urandom_range(99) < pct) begin
         start     = 1'b0;
         req_func  = ($urandom_range(1) == 0) ? chth_pkg::FUNC_ADD : chth_pkg::FUNC_LOOKUP;
         req_key   = chth_pkg::KEY_W'({$urandom, $urandom});
         req_delta = $urandom;
         @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start = 1'b0;
      while (tracker.expected_counts.size() != 0) @(negedge clock);
   endtask

   // mostly keys already in the table or sharing a bucket with one
   function automatic logic [chth_pkg::KEY_W-1:0] pick_key();
      int                         sel;
      logic [chth_pkg::KEY_W-1:0] base;
      sel = $urandom_range(99);
      if (known_keys.size() == 0 || sel >= 85) return chth_pkg::KEY_W'({$urandom, $urandom});
      base = known_keys[$urandom_range(known_keys.size() - 1)];
      if (sel < 45) return base;
      if (sel < 70)
         return base + chth_pkg::KEY_W'(chth_pkg::BUCKETS)
                     * chth_pkg::KEY_W'($urandom_range(1, 40));
      return chth_pkg::KEY_W'($urandom_range(4000));
   endfunction

   function automatic logic signed [chth_pkg::CNT_W-1:0] pick_delta();
      case ($urandom_range(19))
         0:       return CNT_MAX;
         1:       return CNT_MIN;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      tracker   = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_func  = chth_pkg::FUNC_ADD;
      req_key   = '0;
      req_delta = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed: empty lookup, count wrap at both ends, key extremes
      send_item(chth_pkg::FUNC_LOOKUP, '0, CNT_MAX);
      send_item(chth_pkg::FUNC_ADD, '0, CNT_MAX);
      send_item(chth_pkg::FUNC_ADD, '0, 1);
      send_item(chth_pkg::FUNC_LOOKUP, '0, -1);
      send_item(chth_pkg::FUNC_ADD, KEY_MAX, CNT_MIN);
      send_item(chth_pkg::FUNC_ADD, KEY_MAX, -1);
      send_item(chth_pkg::FUNC_LOOKUP, KEY_MAX, 0);
      // one bucket chain of eleven, then hit the deepest, the middle and a miss
      for (int i = 0; i <= 10; i++)
         send_item(chth_pkg::FUNC_ADD, chth_pkg::KEY_W'(5 + chth_pkg::BUCKETS * i), i - 5);
      send_item(chth_pkg::FUNC_LOOKUP, chth_pkg::KEY_W'(5), CNT_MIN);
      send_item(chth_pkg::FUNC_LOOKUP, chth_pkg::KEY_W'(5 + chth_pkg::BUCKETS * 11), 7);
      send_item(chth_pkg::FUNC_ADD, chth_pkg::KEY_W'(5 + chth_pkg::BUCKETS * 5), 0);
      send_item(chth_pkg::FUNC_ADD, chth_pkg::KEY_W'(7), 0);
      wait_for_drain();

      // random phases: back to back, sparse sender, mixed
      foreach (idle_pct[p]) begin
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            hold_off((i % 64 < 12) ? 0 : idle_pct[p]);
            if ($urandom_range(199) == 0) wait_for_drain();
            send_item(($urandom_range(1) == 0) ? chth_pkg::FUNC_ADD : chth_pkg::FUNC_LOOKUP,
                      pick_key(), pick_delta());
         end
         wait_for_drain();
      end

      // mixed tail: fresh keys alternating with keys from pick_key
      for (int i = 0; i < 40; i++) begin
         hold_off(37);
         send_item(($urandom_range(1) == 0) ? chth_pkg::FUNC_ADD : chth_pkg::FUNC_LOOKUP,
                   (i % 2 == 0) ? chth_pkg::KEY_W'({$urandom, $urandom}) : pick_key(),
                   pick_delta());
      end
      wait_for_drain();
      repeat (200) @(posedge clock);

      if (tracker.errors == 0)
         $display("tb_chained_hash_counter_table_top: PASS");
      else
         $display("tb_chained_hash_counter_table_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/chth_pkg.sv
rtl/chth_mod_unit.sv
rtl/chained_hash_counter_table_top.sv
bench/tb_chained_hash_counter_table_top.sv
